// File: design/gbdse_pkg.sv
// ----------------------------------------------------------------------------
// gbdse_pkg
// Types and codes shared by the grid search step engine.
// ----------------------------------------------------------------------------
package gbdse_pkg;

	localparam int MAX_WIDTH      = 64;
	localparam int MAX_HEIGHT     = 64;
	localparam int FRONTIER_DEPTH = 16384;
	localparam int CELL_AW        = 12;
	localparam int FRONT_AW       = 14;

	localparam logic [1:0] OP_RESTART = 2'd0;
	localparam logic [1:0] OP_MARK    = 2'd1;
	localparam logic [1:0] OP_STEP    = 2'd2;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SKIP     = 3'd1;
	localparam logic [2:0] ST_EXPAND   = 3'd2;
	localparam logic [2:0] ST_GOAL     = 3'd3;
	localparam logic [2:0] ST_BAD      = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;

	localparam logic [2:0] LBL_UNVISITED = 3'd0;
	localparam logic [2:0] LBL_NEAR      = 3'd1;
	localparam logic [2:0] LBL_VISITED   = 3'd2;
	localparam logic [2:0] LBL_OBSTACLE  = 3'd3;
	localparam logic [2:0] LBL_START     = 3'd4;
	localparam logic [2:0] LBL_END       = 3'd5;

	localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
	localparam logic [2:0] REG_SEARCH_MODE = 3'd2;
	localparam logic [2:0] REG_START_X     = 3'd3;
	localparam logic [2:0] REG_START_Y     = 3'd4;
	localparam logic [2:0] REG_END_X       = 3'd5;
	localparam logic [2:0] REG_END_Y       = 3'd6;

	typedef struct packed {
		logic [1:0] op;
		logic [5:0] cell_x;
		logic [5:0] cell_y;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  popped_x;
		logic [5:0]  popped_y;
		logic [2:0]  pushed_count;
		logic [14:0] frontier_count;
		logic        running_flag;
	} out_item_t;

endpackage

// File: design/grid_bfs_dfs_step_engine.sv
// ----------------------------------------------------------------------------
// grid_bfs_dfs_step_engine
// Single-step breadth-first / depth-first search over a 4-connected grid.
//
//   channel  | handshake                   | payload
//   in       | in_valid / in_ready         | in_data  (op, cell_x, cell_y)
//   out      | out_valid / out_ready       | out_data (status ... running_flag)
//   cfg      | cfg_we, cfg_idx             | cfg_wdata
//
// A step that expands a cell reads each neighbour inside the grid from the
// cell memory and then evaluates it. A restart sweeps all 4096 cells.
// After reset the cell memories are cleared; no transaction is accepted
// until then. Items are processed one at a time; a finished result waits
// in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module grid_bfs_dfs_step_engine
	import gbdse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [2:0] cfg_idx,
	input  logic [6:0] cfg_wdata
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RST_CLR, S_RST_START, S_RST_END,
		S_POP_RD, S_POP_CHK, S_CELL, S_NB_RD, S_NB_EV, S_DONE
	} state_t;

	state_t state_q;

	logic [6:0] grid_width_q, grid_height_q;
	logic       search_mode_q;
	logic [5:0] start_x_q, start_y_q, end_x_q, end_y_q;

	logic [CELL_AW-1:0]  clr_addr_q;
	logic [FRONT_AW-1:0] head_q;
	logic [14:0]         fill_q;
	logic                running_q;
	logic [2:0]          status_q;
	logic [5:0]          px_q, py_q;
	logic [2:0]          pushed_q;
	logic [1:0]          nb_q;
	logic                out_valid_q;
	out_item_t           out_q;

	// Memories.
	logic [2:0] lbl_mem [0:(1<<CELL_AW)-1];
	logic       vis_mem [0:(1<<CELL_AW)-1];
	logic [CELL_AW-1:0] fr_mem [0:FRONTIER_DEPTH-1];

	logic [2:0] lbl_rd_q;
	logic       vis_rd_q;
	logic [CELL_AW-1:0] fr_rd_q;

	logic lbl_we, vis_we, vis_wd, fr_we;
	logic [CELL_AW-1:0]  lbl_wa, cell_ra, fr_wd;
	logic [2:0]          lbl_wd;
	logic [FRONT_AW-1:0] fr_wa, fr_ra;

	logic [6:0] w_eff, h_eff;
	logic       in_acc, mark_bad, rst_bad, out_free;
	logic [5:0] pop_x, pop_y, nx, ny;
	logic       nb_ok;
	logic [FRONT_AW-1:0] tail_addr;

	assign w_eff = (grid_width_q == 7'd0) ? 7'd1 :
		(grid_width_q > 7'(MAX_WIDTH) ? 7'(MAX_WIDTH) : grid_width_q);
	assign h_eff = (grid_height_q == 7'd0) ? 7'd1 :
		(grid_height_q > 7'(MAX_HEIGHT) ? 7'(MAX_HEIGHT) : grid_height_q);

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign mark_bad = ({1'b0, in_data.cell_x} >= w_eff) || ({1'b0, in_data.cell_y} >= h_eff);
	assign rst_bad  = ({1'b0, start_x_q} >= w_eff) || ({1'b0, start_y_q} >= h_eff) ||
		({1'b0, end_x_q} >= w_eff) || ({1'b0, end_y_q} >= h_eff);
	assign pop_x     = fr_rd_q[5:0];
	assign pop_y     = fr_rd_q[11:6];
	assign tail_addr = head_q + fill_q[FRONT_AW-1:0];

	// Neighbour order: breadth-first right, left, down, up;
	// depth-first left, right, up, down.
	always_comb begin
		logic [1:0] dir;
		dir = search_mode_q ? {nb_q[1], ~nb_q[0]} : nb_q;
		nx = px_q;
		ny = py_q;
		nb_ok = 1'b0;
		case (dir)
			2'd0: begin
				nb_ok = ({1'b0, px_q} + 7'd1) < w_eff;
				nx = px_q + 6'd1;
			end
			2'd1: begin
				nb_ok = (px_q != 6'd0);
				nx = px_q - 6'd1;
			end
			2'd2: begin
				nb_ok = ({1'b0, py_q} + 7'd1) < h_eff;
				ny = py_q + 6'd1;
			end
			default: begin
				nb_ok = (py_q != 6'd0);
				ny = py_q - 6'd1;
			end
		endcase
	end

	always_comb begin
		lbl_we = 1'b0;
		vis_we = 1'b0;
		fr_we  = 1'b0;
		lbl_wa = clr_addr_q;
		lbl_wd = LBL_UNVISITED;
		vis_wd = 1'b0;
		fr_wa  = tail_addr;
		fr_wd  = {ny, nx};
		cell_ra = {ny, nx};
		fr_ra  = search_mode_q ? tail_addr - FRONT_AW'(1) : head_q;
		unique case (state_q)
			S_CLEAR, S_RST_CLR: begin
				lbl_we = 1'b1;
				vis_we = 1'b1;
			end
			S_IDLE: begin
				if (in_acc && in_data.op == OP_MARK && !mark_bad) begin
					lbl_we = 1'b1;
					lbl_wa = {in_data.cell_y, in_data.cell_x};
					lbl_wd = LBL_OBSTACLE;
				end
			end
			S_RST_START: begin
				lbl_we = 1'b1;
				lbl_wa = {start_y_q, start_x_q};
				lbl_wd = LBL_START;
			end
			S_RST_END: begin
				// The goal label goes in after the start label, so it wins
				// when both name the same cell. The start cell is pushed here.
				lbl_we = 1'b1;
				lbl_wa = {end_y_q, end_x_q};
				lbl_wd = LBL_END;
				fr_we  = 1'b1;
				fr_wa  = '0;
				fr_wd  = {start_y_q, start_x_q};
			end
			S_POP_CHK: cell_ra = fr_rd_q;
			S_CELL: begin
				lbl_wa = {py_q, px_q};
				vis_wd = 1'b1;
				if (!vis_rd_q && lbl_rd_q != LBL_END) begin
					vis_we = 1'b1;
					if (lbl_rd_q != LBL_OBSTACLE && lbl_rd_q != LBL_START) begin
						lbl_we = 1'b1;
						lbl_wd = LBL_VISITED;
					end
				end
			end
			S_NB_EV: begin
				lbl_wa = {ny, nx};
				lbl_wd = LBL_NEAR;
				if (!(search_mode_q && (vis_rd_q || lbl_rd_q == LBL_OBSTACLE)) && !fill_q[14]) begin
					fr_we  = 1'b1;
					lbl_we = (lbl_rd_q == LBL_UNVISITED);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (lbl_we) lbl_mem[lbl_wa] <= lbl_wd;
		if (vis_we) vis_mem[lbl_wa] <= vis_wd;
		if (fr_we) fr_mem[fr_wa] <= fr_wd;
		lbl_rd_q <= lbl_mem[cell_ra];
		vis_rd_q <= vis_mem[cell_ra];
		fr_rd_q  <= fr_mem[fr_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_addr_q    <= '0;
			head_q        <= '0;
			fill_q        <= '0;
			running_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			grid_width_q  <= 7'd16;
			grid_height_q <= 7'd16;
			search_mode_q <= 1'b0;
			start_x_q     <= 6'd0;
			start_y_q     <= 6'd0;
			end_x_q       <= 6'd15;
			end_y_q       <= 6'd15;
			status_q      <= ST_IDLE;
			px_q          <= '0;
			py_q          <= '0;
			pushed_q      <= '0;
			nb_q          <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata;
					REG_GRID_HEIGHT: grid_height_q <= cfg_wdata;
					REG_SEARCH_MODE: search_mode_q <= cfg_wdata[0];
					REG_START_X:     start_x_q     <= cfg_wdata[5:0];
					REG_START_Y:     start_y_q     <= cfg_wdata[5:0];
					REG_END_X:       end_x_q       <= cfg_wdata[5:0];
					REG_END_Y:       end_y_q       <= cfg_wdata[5:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && state_q != S_DONE) out_valid_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + CELL_AW'(1);
					if (&clr_addr_q) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc) begin
						status_q <= ST_IDLE;
						px_q     <= '0;
						py_q     <= '0;
						pushed_q <= '0;
						unique case (in_data.op)
							OP_RESTART: begin
								head_q     <= '0;
								fill_q     <= '0;
								running_q  <= 1'b0;
								clr_addr_q <= '0;
								state_q    <= S_RST_CLR;
							end
							OP_MARK: begin
								if (mark_bad) status_q <= ST_BAD;
								state_q <= S_DONE;
							end
							OP_STEP: begin
								state_q <= (running_q && fill_q != '0) ? S_POP_RD : S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_RST_CLR: begin
					clr_addr_q <= clr_addr_q + CELL_AW'(1);
					if (&clr_addr_q) begin
						if (rst_bad) begin
							status_q <= ST_BAD;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_RST_START;
						end
					end
				end
				S_RST_START: begin
					px_q    <= start_x_q;
					py_q    <= start_y_q;
					state_q <= S_RST_END;
				end
				S_RST_END: begin
					fill_q    <= 15'd1;
					pushed_q  <= 3'd1;
					running_q <= 1'b1;
					px_q      <= '0;
					py_q      <= '0;
					state_q   <= S_DONE;
				end
				S_POP_RD: begin
					if (!search_mode_q) head_q <= head_q + FRONT_AW'(1);
					fill_q  <= fill_q - 15'd1;
					state_q <= S_POP_CHK;
				end
				S_POP_CHK: begin
					px_q <= pop_x;
					py_q <= pop_y;
					if (({1'b0, pop_x} >= w_eff) || ({1'b0, pop_y} >= h_eff)) begin
						status_q <= ST_BAD;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_CELL;
					end
				end
				S_CELL: begin
					if (vis_rd_q || lbl_rd_q == LBL_OBSTACLE) begin
						status_q <= ST_SKIP;
						state_q  <= S_DONE;
					end else if (lbl_rd_q == LBL_END) begin
						status_q  <= ST_GOAL;
						head_q    <= '0;
						fill_q    <= '0;
						running_q <= 1'b0;
						state_q   <= S_DONE;
					end else begin
						status_q <= ST_EXPAND;
						nb_q     <= '0;
						state_q  <= S_NB_RD;
					end
				end
				S_NB_RD: begin
					if (nb_ok) begin
						state_q <= S_NB_EV;
					end else begin
						nb_q <= nb_q + 2'd1;
						if (&nb_q) state_q <= S_DONE;
					end
				end
				S_NB_EV: begin
					if (!(search_mode_q && (vis_rd_q || lbl_rd_q == LBL_OBSTACLE))) begin
						if (fill_q[14]) begin
							status_q <= ST_OVERFLOW;
						end else begin
							fill_q   <= fill_q + 15'd1;
							pushed_q <= pushed_q + 3'd1;
						end
					end
					nb_q    <= nb_q + 2'd1;
					state_q <= (&nb_q) ? S_DONE : S_NB_RD;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q <= '{status: status_q, popped_x: px_q, popped_y: py_q,
							pushed_count: pushed_q, frontier_count: fill_q,
							running_flag: running_q};
						state_q <= S_IDLE;
					end else if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 15'(FRONTIER_DEPTH))
		else $error("frontier fill exceeds depth");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion");

	a_pushed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pushed_q <= 3'd4)
		else $error("more than four pushes in one step");

	a_goal_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CELL && !vis_rd_q && lbl_rd_q == LBL_END)
		|=> (!running_q && fill_q == '0))
		else $error("goal did not stop the run");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Grid search step engine testbench
// Sends restart, mark and step transactions with bursty input and a stalling
// output. Results are checked against a fixed expectation or a behavioral
// copy of the engine kept in step with accepted inputs and register writes.
// ----------------------------------------------------------------------------
module testbench;
	import gbdse_pkg::*;

	localparam int IDLE_LIMIT = 30000;
	localparam int LONG_HOLD  = 300;
	localparam logic [1:0] OP_NOP = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_we;
	logic [2:0] cfg_idx;
	logic [6:0] cfg_wdata;

	grid_bfs_dfs_step_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// Shadow of the engine: registers, cell memories and frontier.
	logic [6:0]  sh_width, sh_height;
	logic        sh_dfs;
	logic [5:0]  sh_sx, sh_sy, sh_ex, sh_ey;
	logic [2:0]  cell_lbl [MAX_WIDTH*MAX_HEIGHT];
	bit          cell_seen [MAX_WIDTH*MAX_HEIGHT];
	logic [11:0] front_mem [FRONTIER_DEPTH];
	int          front_head, front_fill;
	bit          search_on;

	out_item_t   result_q[$];
	int          errors = 0;
	int          n_goal, n_expand, n_skip, n_bad, n_restart;
	bit          hold_req;
	int          quiet_cycles = 0;

	typedef struct {
		bit        is_cfg;
		logic [2:0] reg_idx;
		logic [6:0] reg_val;
		in_item_t  item;
		bit        typed;
		out_item_t want;
	} row_t;
	row_t plan[$];

	function automatic int grid_w();
		if (sh_width == 0) return 1;
		return (sh_width > MAX_WIDTH) ? MAX_WIDTH : int'(sh_width);
	endfunction

	function automatic int grid_h();
		if (sh_height == 0) return 1;
		return (sh_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(sh_height);
	endfunction

	function automatic bit front_push(int x, int y);
		if (front_fill >= FRONTIER_DEPTH) return 0;
		front_mem[(front_head + front_fill) % FRONTIER_DEPTH] = 12'(y * MAX_WIDTH + x);
		front_fill++;
		return 1;
	endfunction

	function automatic int offer_neighbour(int x, int y, ref bit dropped);
		int k;
		k = y * MAX_WIDTH + x;
		if (sh_dfs && (cell_seen[k] || cell_lbl[k] == LBL_OBSTACLE)) return 0;
		if (!front_push(x, y)) begin
			dropped = 1;
			return 0;
		end
		if (cell_lbl[k] == LBL_UNVISITED) cell_lbl[k] = LBL_NEAR;
		return 1;
	endfunction

	function automatic void wipe_search();
		for (int i = 0; i < MAX_WIDTH*MAX_HEIGHT; i++) begin
			cell_lbl[i] = LBL_UNVISITED;
			cell_seen[i] = 0;
		end
		front_head = 0;
		front_fill = 0;
		search_on = 0;
	endfunction

	// Applies one transaction to the shadow and returns the result it yields.
	function automatic out_item_t search_step(in_item_t it);
		out_item_t r;
		int w, h, x, y, k, n;
		logic [11:0] v;
		bit dropped;
		w = grid_w();
		h = grid_h();
		r = '0;
		n = 0;
		dropped = 0;
		if (it.op == OP_RESTART) begin
			n_restart++;
			wipe_search();
			if (sh_sx >= w || sh_sy >= h || sh_ex >= w || sh_ey >= h) begin
				r.status = ST_BAD;
			end else begin
				cell_lbl[sh_sy*MAX_WIDTH + sh_sx] = LBL_START;
				cell_lbl[sh_ey*MAX_WIDTH + sh_ex] = LBL_END;
				void'(front_push(sh_sx, sh_sy));
				n = 1;
				search_on = 1;
			end
		end else if (it.op == OP_MARK) begin
			if (it.cell_x >= w || it.cell_y >= h) r.status = ST_BAD;
			else cell_lbl[it.cell_y*MAX_WIDTH + it.cell_x] = LBL_OBSTACLE;
		end else if (it.op == OP_STEP && search_on && front_fill != 0) begin
			if (sh_dfs) begin
				v = front_mem[(front_head + front_fill - 1) % FRONTIER_DEPTH];
			end else begin
				v = front_mem[front_head];
				front_head = (front_head + 1) % FRONTIER_DEPTH;
			end
			front_fill--;
			x = v % MAX_WIDTH;
			y = v / MAX_WIDTH;
			r.popped_x = 6'(x);
			r.popped_y = 6'(y);
			k = y * MAX_WIDTH + x;
			if (x >= w || y >= h) begin
				r.status = ST_BAD;
			end else if (cell_seen[k]) begin
				r.status = ST_SKIP;
			end else if (cell_lbl[k] == LBL_END) begin
				r.status = ST_GOAL;
				front_head = 0;
				front_fill = 0;
				search_on = 0;
			end else if (cell_lbl[k] == LBL_OBSTACLE) begin
				cell_seen[k] = 1;
				r.status = ST_SKIP;
			end else begin
				cell_seen[k] = 1;
				if (cell_lbl[k] != LBL_START) cell_lbl[k] = LBL_VISITED;
				if (sh_dfs) begin
					if (x > 0) n += offer_neighbour(x - 1, y, dropped);
					if (x + 1 < w) n += offer_neighbour(x + 1, y, dropped);
					if (y > 0) n += offer_neighbour(x, y - 1, dropped);
					if (y + 1 < h) n += offer_neighbour(x, y + 1, dropped);
				end else begin
					if (x + 1 < w) n += offer_neighbour(x + 1, y, dropped);
					if (x > 0) n += offer_neighbour(x - 1, y, dropped);
					if (y + 1 < h) n += offer_neighbour(x, y + 1, dropped);
					if (y > 0) n += offer_neighbour(x, y - 1, dropped);
				end
				r.status = dropped ? ST_OVERFLOW : ST_EXPAND;
			end
		end
		case (r.status)
			ST_GOAL:                n_goal++;
			ST_EXPAND, ST_OVERFLOW: n_expand++;
			ST_SKIP:                n_skip++;
			ST_BAD:                 n_bad++;
			default: ;
		endcase
		r.pushed_count = 3'(n);
		r.frontier_count = 15'(front_fill);
		r.running_flag = search_on;
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Watchdog: counts cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Output side: stall pattern, one long hold on request, result checking.
	initial begin
		int stretch, style, held;
		bit hold_done;
		out_item_t want;
		out_ready = 0;
		stretch = 0;
		style = 0;
		held = 0;
		hold_done = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 0;
				held++;
				if (held >= LONG_HOLD) hold_done = 1;
			end else begin
				held = 0;
				if (stretch == 0) begin
					stretch = $urandom_range(8, 60);
					style = $urandom_range(0, 2);
				end
				stretch--;
				case (style)
					0: out_ready <= 1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= (stretch % 5 == 0);
				endcase
			end
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected, got %p", $time, out_data);
				end else begin
					want = result_q.pop_front();
					check_field("status", want.status, out_data.status);
					check_field("popped_x", want.popped_x, out_data.popped_x);
					check_field("popped_y", want.popped_y, out_data.popped_y);
					check_field("pushed_count", want.pushed_count, out_data.pushed_count);
					check_field("frontier_count", want.frontier_count,
						out_data.frontier_count);
					check_field("running_flag", want.running_flag, out_data.running_flag);
				end
			end
		end
	end

	task automatic send(in_item_t it, bit typed, out_item_t want);
		out_item_t r;
		@(negedge clk);
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		r = search_step(it);
		result_q.push_back(typed ? want : r);
	endtask

	task automatic pause_sender(int cycles);
		@(negedge clk);
		in_valid <= 0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain();
		pause_sender(0);
		while (result_q.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [6:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_GRID_WIDTH:  sh_width = val;
			REG_GRID_HEIGHT: sh_height = val;
			REG_SEARCH_MODE: sh_dfs = val[0];
			REG_START_X:     sh_sx = val[5:0];
			REG_START_Y:     sh_sy = val[5:0];
			REG_END_X:       sh_ex = val[5:0];
			default:         sh_ey = val[5:0];
		endcase
	endtask

	function automatic void add_item(logic [1:0] op, int x, int y);
		row_t r;
		r = '{default: '0};
		r.item = '{op: op, cell_x: 6'(x), cell_y: 6'(y)};
		plan.push_back(r);
	endfunction

	function automatic void add_typed(logic [1:0] op, int x, int y, out_item_t want);
		add_item(op, x, y);
		plan[$].typed = 1;
		plan[$].want = want;
	endfunction

	function automatic void add_cfg(logic [2:0] idx, int val);
		row_t r;
		r = '{default: '0};
		r.is_cfg = 1;
		r.reg_idx = idx;
		r.reg_val = 7'(val);
		plan.push_back(r);
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		it.cell_x = 6'($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
			: $urandom_range(0, grid_w()));
		it.cell_y = 6'($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
			: $urandom_range(0, grid_h()));
		if (pick < 70) it.op = OP_STEP;
		else if (pick < 90) it.op = OP_MARK;
		else if (pick < 95) it.op = OP_NOP;
		else it.op = OP_RESTART;
		return it;
	endfunction

	function automatic int pick_size();
		int p;
		p = $urandom_range(0, 19);
		if (p == 0) return 0;
		if (p == 1) return 127;
		if (p == 2) return 64;
		if (p == 3) return 1;
		return $urandom_range(2, 9);
	endfunction

	initial begin
		in_item_t it;
		int sent, burst, len;
		bit fresh;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_idx = REG_GRID_WIDTH;
		cfg_wdata = '0;
		hold_req = 0;
		sh_width = 16;
		sh_height = 16;
		sh_dfs = 0;
		sh_sx = 0;
		sh_sy = 0;
		sh_ex = 15;
		sh_ey = 15;
		wipe_search();
		repeat (8) @(negedge clk);
		arst_n = 1;

		// Directed part: reset values, edges of the grid and every status but overflow.
		add_typed(OP_NOP, 63, 63, '0);
		add_typed(OP_STEP, 0, 0, '0);
		add_typed(OP_MARK, 16, 0, '{ST_BAD, 0, 0, 0, 0, 0});
		add_typed(OP_MARK, 63, 63, '{ST_BAD, 0, 0, 0, 0, 0});
		add_typed(OP_RESTART, 0, 0, '{ST_IDLE, 0, 0, 1, 1, 1});
		add_item(OP_MARK, 1, 0);
		repeat (4) add_item(OP_STEP, 0, 0);
		add_cfg(REG_SEARCH_MODE, 1);
		repeat (3) add_item(OP_STEP, 0, 0);
		add_cfg(REG_GRID_WIDTH, 1);
		add_cfg(REG_GRID_HEIGHT, 1);
		add_cfg(REG_END_X, 0);
		add_cfg(REG_END_Y, 0);
		add_item(OP_RESTART, 0, 0);
		add_typed(OP_STEP, 0, 0, '{ST_GOAL, 0, 0, 0, 0, 0});
		add_typed(OP_STEP, 0, 0, '0);
		add_cfg(REG_END_X, 63);
		add_typed(OP_RESTART, 0, 0, '{ST_BAD, 0, 0, 0, 0, 0});
		add_cfg(REG_GRID_WIDTH, 127);
		add_cfg(REG_GRID_HEIGHT, 127);
		add_cfg(REG_END_Y, 63);
		add_cfg(REG_START_X, 63);
		add_item(OP_RESTART, 0, 0);
		add_item(OP_STEP, 0, 0);
		add_item(OP_MARK, 0, 63);
		add_item(OP_MARK, 63, 63);
		add_item(OP_STEP, 0, 0);
		add_cfg(REG_GRID_WIDTH, 0);
		add_cfg(REG_GRID_HEIGHT, 0);
		add_item(OP_STEP, 0, 0);
		add_cfg(REG_GRID_WIDTH, 2);
		add_cfg(REG_GRID_HEIGHT, 2);
		add_cfg(REG_SEARCH_MODE, 0);
		add_cfg(REG_START_X, 0);
		add_cfg(REG_START_Y, 0);
		add_cfg(REG_END_X, 1);
		add_cfg(REG_END_Y, 1);
		add_item(OP_RESTART, 0, 0);
		repeat (4) add_item(OP_STEP, 0, 0);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send(plan[i].item, plan[i].typed, plan[i].want);
			end
		end

		// Random part: each phase sets up a grid, usually restarts, then mostly
		// steps with marks mixed in. Phases without a restart carry the old run
		// over a changed mode or grid size.
		sent = 0;
		while (sent < 470) begin
			drain();
			write_reg(REG_GRID_WIDTH, 7'(pick_size()));
			write_reg(REG_GRID_HEIGHT, 7'(pick_size()));
			write_reg(REG_SEARCH_MODE, 7'($urandom_range(0, 1)));
			fresh = ($urandom_range(0, 9) < 7);
			if (fresh) begin
				write_reg(REG_START_X, 7'($urandom_range(0, 9) == 0 ? 63 : $urandom_range(0, grid_w() - 1)));
				write_reg(REG_START_Y, 7'($urandom_range(0, grid_h() - 1)));
				write_reg(REG_END_X, 7'($urandom_range(0, grid_w() - 1)));
				write_reg(REG_END_Y, 7'($urandom_range(0, 9) == 0 ? 63 : $urandom_range(0, grid_h() - 1)));
				it = '{op: OP_RESTART, cell_x: 6'($urandom), cell_y: 6'($urandom)};
				send(it, 0, '0);
				sent++;
			end
			// The receiver takes its one long hold once the run is under way.
			if (sent > 100) hold_req = 1;
			len = $urandom_range(15, 30);
			burst = 0;
			for (int n = 0; n < len; n++) begin
				if (burst == 0) begin
					burst = $urandom_range(1, 12);
					if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 10));
				end
				burst--;
				send(random_item(), 0, '0);
				sent++;
			end
		end

		drain();
		repeat (40) @(negedge clk);
		$display("covered %0d restarts, %0d expansions, %0d goals, %0d skips, %0d bad coordinates",
			n_restart, n_expand, n_goal, n_skip, n_bad);
		$display("mixed breadth-first and depth-first runs, grid sizes from 1x1 up to 64x64");
		if (errors == 0 && result_q.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
